// ===== design/dsa_signature_verify_core_macros.svh =====
// Assertion macros shared by the signature check design
`ifndef DSA_SIGNATURE_VERIFY_CORE_MACROS_SVH
`define DSA_SIGNATURE_VERIFY_CORE_MACROS_SVH
// Implication checked on every clock edge outside reset
`define DSV_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// Implication whose consequent is checked in the cycle after the antecedent
`define DSV_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ===== design/dsv_pkg.sv =====
// ----------------------------------------------------------------------------
// dsv_pkg
// Types and constants shared by the signature check core.
// ----------------------------------------------------------------------------
`default_nettype none
package dsv_pkg;
  localparam int unsigned W = 32;

  localparam logic [1:0] REG_P = 2'd0;
  localparam logic [1:0] REG_Q = 2'd1;
  localparam logic [1:0] REG_G = 2'd2;
  localparam logic [1:0] REG_Y = 2'd3;

  typedef struct packed {
    logic [W-1:0] message_value;
    logic [W-1:0] sig_r;
    logic [W-1:0] sig_s;
  } in_item_t;

  typedef struct packed {
    logic         sig_valid;
    logic [W-1:0] check_value;
  } out_item_t;

  // Datapath operations
  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,      // latch the item's fields
    OP_DIV_GO,    // load dividend and divisor selected by src
    OP_DIV_STEP,  // one quotient bit
    OP_MUL_GO,    // load multiplier operands selected by src
    OP_MUL_STEP,  // one multiplier bit
    OP_EUC_INIT,  // start Euclid from s mod q, w = 1
    OP_EUC_UPD,   // rotate Euclid remainders and coefficients
    OP_W_FIX,     // take the inverse when the gcd is one
    OP_PUT_U1,    // u1 = product
    OP_PUT_U2,    // u2 = product
    OP_BASE_G,    // start g^u1 mod p
    OP_BASE_Y,    // start y^u2 mod p
    OP_PUT_ACC,   // acc = product
    OP_PUT_SQ,    // base = product, drop one exponent bit
    OP_PUT_GPOW,  // hold g^u1 mod p
    OP_PUT_OUT,   // latch the result
    OP_PUT_ZERO   // latch the zero-modulus result
  } op_t;

  // Operand sources for the divider and the multiplier
  typedef enum logic [3:0] {
    SRC_S_Q,    // s / q
    SRC_MSG_Q,  // message / q
    SRC_R_Q,    // r / q
    SRC_G_P,    // g / p
    SRC_Y_P,    // y / p
    SRC_EUC,    // r0 / r1, or t1 * quotient mod q
    SRC_V_Q,    // product / q
    SRC_W,      // remainder * w mod q
    SRC_ACC,    // acc * base mod p
    SRC_SQ,     // base * base mod p
    SRC_V       // g^u1 * y^u2 mod p
  } src_t;

  typedef struct packed {
    op_t  op;
    src_t src;
  } cmd_t;

  typedef struct packed {
    logic zero_mod;  // p or q is zero
    logic rem_zero;  // divider remainder is zero
    logic r1_zero;   // Euclid remainder zero
    logic e_zero;    // working exponent exhausted
    logic e_lsb;     // low bit of the working exponent
    logic div_last;  // divider takes its last bit this cycle
    logic mul_done;  // multiplier has no bits left
  } stat_t;
endpackage
`default_nettype wire

// ===== design/dsv_datapath.sv =====
// ----------------------------------------------------------------------------
// dsv_datapath
// Registers, a shift-subtract divider and a shift-add modular multiplier
// for the signature check, driven one command per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
`include "dsa_signature_verify_core_macros.svh"
module dsv_datapath (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire dsv_pkg::cmd_t     cmd,
  input  wire dsv_pkg::in_item_t in_item,
  input  wire logic [31:0]       p,
  input  wire logic [31:0]       q,
  input  wire logic [31:0]       g,
  input  wire logic [31:0]       y,
  output dsv_pkg::stat_t         stat,
  output dsv_pkg::out_item_t     res
);
  // Item fields
  logic [31:0] msg, r, s;
  // Euclid registers, inverse and scalars
  logic [31:0] r0, r1, t0, t1, w, u1, u2;
  // Exponentiation registers
  logic [31:0] base, e, acc, gpow;
  // Divider: dividend shifts out at the top, quotient and remainder build up
  logic [31:0] dnum, den, dq, dr;
  logic [4:0]  cnt;
  logic [32:0] rem_try, rem_sub;
  logic        rem_ge;
  // Multiplier: mc accumulates ma*mb mod mm while ma doubles and mb shifts
  logic [31:0] ma, mb, mm, mc;
  logic [31:0] gap, mc_add, ma_dbl;
  logic [31:0] t1_next;

  // Divider step: shift the next dividend bit into the remainder
  always_comb begin
    rem_try = {dr, dnum[31]};
    rem_sub = rem_try - {1'b0, den};
    rem_ge  = (rem_try >= {1'b0, den});
  end

  // Modular add and double, operands below mm
  always_comb begin
    gap    = mm - ma;
    mc_add = (mc >= gap) ? mc - gap : mc + ma;
    ma_dbl = (ma >= gap) ? ma - gap : ma + ma;
  end

  // Next Bezout coefficient t0 - qt*t1 mod q
  always_comb begin
    t1_next = (t0 >= mc) ? t0 - mc : t0 + (q - mc);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      res <= '0;
    end else begin
      unique case (cmd.op)
        dsv_pkg::OP_LOAD: begin
          msg <= in_item.message_value;
          r   <= in_item.sig_r;
          s   <= in_item.sig_s;
        end
        dsv_pkg::OP_DIV_GO: begin
          cnt <= '0;
          dq  <= '0;
          dr  <= '0;
          unique case (cmd.src)
            dsv_pkg::SRC_MSG_Q: begin dnum <= msg; den <= q;  end
            dsv_pkg::SRC_R_Q:   begin dnum <= r;   den <= q;  end
            dsv_pkg::SRC_G_P:   begin dnum <= g;   den <= p;  end
            dsv_pkg::SRC_Y_P:   begin dnum <= y;   den <= p;  end
            dsv_pkg::SRC_EUC:   begin dnum <= r0;  den <= r1; end
            dsv_pkg::SRC_V_Q:   begin dnum <= mc;  den <= q;  end
            default:            begin dnum <= s;   den <= q;  end
          endcase
        end
        dsv_pkg::OP_DIV_STEP: begin
          dnum <= {dnum[30:0], 1'b0};
          dr   <= rem_ge ? rem_sub[31:0] : rem_try[31:0];
          dq   <= {dq[30:0], rem_ge};
          cnt  <= cnt + 5'd1;
        end
        dsv_pkg::OP_MUL_GO: begin
          mc <= '0;
          unique case (cmd.src)
            dsv_pkg::SRC_EUC: begin ma <= t1;   mb <= dq;   mm <= q; end
            dsv_pkg::SRC_ACC: begin ma <= acc;  mb <= base; mm <= p; end
            dsv_pkg::SRC_SQ:  begin ma <= base; mb <= base; mm <= p; end
            dsv_pkg::SRC_V:   begin ma <= gpow; mb <= acc;  mm <= p; end
            default:          begin ma <= dr;   mb <= w;    mm <= q; end
          endcase
        end
        dsv_pkg::OP_MUL_STEP: begin
          if (mb[0]) mc <= mc_add;
          ma <= ma_dbl;
          mb <= {1'b0, mb[31:1]};
        end
        dsv_pkg::OP_EUC_INIT: begin
          r0 <= dr;
          r1 <= q;
          t0 <= 32'd1;
          t1 <= '0;
          w  <= 32'd1;
        end
        dsv_pkg::OP_EUC_UPD: begin
          r0 <= r1;
          r1 <= dr;
          t0 <= t1;
          t1 <= t1_next;
        end
        dsv_pkg::OP_W_FIX: begin
          w <= (r0 == 32'd1) ? t0 : 32'd1;
        end
        dsv_pkg::OP_PUT_U1: u1 <= mc;
        dsv_pkg::OP_PUT_U2: u2 <= mc;
        dsv_pkg::OP_BASE_G: begin
          base <= dr;
          e    <= u1;
          acc  <= (p == 32'd1) ? 32'd0 : 32'd1;
        end
        dsv_pkg::OP_BASE_Y: begin
          base <= dr;
          e    <= u2;
          acc  <= (p == 32'd1) ? 32'd0 : 32'd1;
        end
        dsv_pkg::OP_PUT_ACC: acc <= mc;
        dsv_pkg::OP_PUT_SQ: begin
          base <= mc;
          e    <= {1'b0, e[31:1]};
        end
        dsv_pkg::OP_PUT_GPOW: gpow <= acc;
        dsv_pkg::OP_PUT_OUT: begin
          res.check_value <= dr;
          res.sig_valid   <= (dr == r);
        end
        dsv_pkg::OP_PUT_ZERO: res <= '0;
        default: ;
      endcase
    end
  end

  // Status
  always_comb begin
    stat.zero_mod = (p == '0) || (q == '0);
    stat.rem_zero = (dr == '0);
    stat.r1_zero  = (r1 == '0);
    stat.e_zero   = (e == '0);
    stat.e_lsb    = e[0];
    stat.div_last = (cnt == 5'd31);
    stat.mul_done = (mb == '0);
  end

  `DSV_ASSERT_NEXT(a_div_go, clk, rst, cmd.op == dsv_pkg::OP_DIV_GO, cnt == '0)
  `DSV_ASSERT_IMPL(a_div_den, clk, rst, cmd.op == dsv_pkg::OP_DIV_STEP, den != '0)
  `DSV_ASSERT_IMPL(a_mul_rng, clk, rst, cmd.op == dsv_pkg::OP_MUL_STEP, (ma < mm) && (mc < mm))
endmodule
`default_nettype wire

// ===== design/dsv_ctrl.sv =====
// ----------------------------------------------------------------------------
// dsv_ctrl
// Sequencer for the signature check: inverse, scalars, exponentiation.
// ----------------------------------------------------------------------------
`default_nettype none
`include "dsa_signature_verify_core_macros.svh"
module dsv_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           start,
  input  wire dsv_pkg::stat_t stat,
  output dsv_pkg::cmd_t       cmd,
  output logic                busy,
  output logic                strobe
);
  typedef enum logic [27:0] {
    S_IDLE  = 28'h0000001, S_REDS  = 28'h0000002, S_SETW  = 28'h0000004,
    S_EDIV  = 28'h0000008, S_EMUL  = 28'h0000010, S_EUPD  = 28'h0000020,
    S_WFIX  = 28'h0000040, S_RMSG  = 28'h0000080, S_U1GO  = 28'h0000100,
    S_U1PUT = 28'h0000200, S_RR    = 28'h0000400, S_U2GO  = 28'h0000800,
    S_U2PUT = 28'h0001000, S_RG    = 28'h0002000, S_GPUT  = 28'h0004000,
    S_EXP   = 28'h0008000, S_XACC  = 28'h0010000, S_XSQGO = 28'h0020000,
    S_XBASE = 28'h0040000, S_RY    = 28'h0080000, S_YPUT  = 28'h0100000,
    S_VGO   = 28'h0200000, S_VRED  = 28'h0400000, S_OUT   = 28'h0800000,
    S_ZERO  = 28'h1000000, S_DONE  = 28'h2000000, S_DIV   = 28'h4000000,
    S_MUL   = 28'h8000000
  } state_t;

  state_t state, state_next;
  state_t ret, ret_next;
  logic   pass, pass_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ret   <= S_IDLE;
      pass  <= 1'b0;
    end else begin
      state <= state_next;
      ret   <= ret_next;
      pass  <= pass_next;
    end
  end

  // Sequence commands; ret names the state that follows a divide or multiply
  always_comb begin
    state_next = state;
    ret_next   = ret;
    pass_next  = pass;
    cmd.op     = dsv_pkg::OP_NONE;
    cmd.src    = dsv_pkg::SRC_S_Q;
    strobe     = 1'b0;
    unique case (state)
      S_IDLE: if (start) begin
        cmd.op = dsv_pkg::OP_LOAD;
        state_next = S_REDS;
      end
      S_REDS: begin
        if (stat.zero_mod) state_next = S_ZERO;
        else begin
          cmd.op = dsv_pkg::OP_DIV_GO; cmd.src = dsv_pkg::SRC_S_Q;
          ret_next = S_SETW; state_next = S_DIV;
        end
      end
      // Run the divider to its last bit
      S_DIV: begin
        cmd.op = dsv_pkg::OP_DIV_STEP;
        if (stat.div_last) state_next = ret;
      end
      // Run the multiplier until its multiplier operand is used up
      S_MUL: begin
        if (stat.mul_done) state_next = ret;
        else cmd.op = dsv_pkg::OP_MUL_STEP;
      end
      // Skip Euclid when s mod q is zero; w stays 1
      S_SETW: begin
        cmd.op = dsv_pkg::OP_EUC_INIT;
        state_next = stat.rem_zero ? S_RMSG : S_EDIV;
      end
      S_EDIV: begin
        if (stat.r1_zero) state_next = S_WFIX;
        else begin
          cmd.op = dsv_pkg::OP_DIV_GO; cmd.src = dsv_pkg::SRC_EUC;
          ret_next = S_EMUL; state_next = S_DIV;
        end
      end
      S_EMUL: begin
        cmd.op = dsv_pkg::OP_MUL_GO; cmd.src = dsv_pkg::SRC_EUC;
        ret_next = S_EUPD; state_next = S_MUL;
      end
      S_EUPD: begin cmd.op = dsv_pkg::OP_EUC_UPD; state_next = S_EDIV; end
      S_WFIX: begin cmd.op = dsv_pkg::OP_W_FIX; state_next = S_RMSG; end
      // u1 = (message mod q) * w mod q
      S_RMSG: begin
        cmd.op = dsv_pkg::OP_DIV_GO; cmd.src = dsv_pkg::SRC_MSG_Q;
        ret_next = S_U1GO; state_next = S_DIV;
      end
      S_U1GO: begin
        cmd.op = dsv_pkg::OP_MUL_GO; cmd.src = dsv_pkg::SRC_W;
        ret_next = S_U1PUT; state_next = S_MUL;
      end
      S_U1PUT: begin cmd.op = dsv_pkg::OP_PUT_U1; state_next = S_RR; end
      // u2 = (r mod q) * w mod q
      S_RR: begin
        cmd.op = dsv_pkg::OP_DIV_GO; cmd.src = dsv_pkg::SRC_R_Q;
        ret_next = S_U2GO; state_next = S_DIV;
      end
      S_U2GO: begin
        cmd.op = dsv_pkg::OP_MUL_GO; cmd.src = dsv_pkg::SRC_W;
        ret_next = S_U2PUT; state_next = S_MUL;
      end
      S_U2PUT: begin cmd.op = dsv_pkg::OP_PUT_U2; state_next = S_RG; end
      // g^u1 mod p first, then y^u2 mod p
      S_RG: begin
        cmd.op = dsv_pkg::OP_DIV_GO; cmd.src = dsv_pkg::SRC_G_P;
        ret_next = S_GPUT; state_next = S_DIV; pass_next = 1'b0;
      end
      S_GPUT: begin cmd.op = dsv_pkg::OP_BASE_G; state_next = S_EXP; end
      S_EXP: begin
        if (stat.e_zero) begin
          if (!pass) begin
            cmd.op = dsv_pkg::OP_PUT_GPOW;
            pass_next = 1'b1; state_next = S_RY;
          end else begin
            state_next = S_VGO;
          end
        end else if (stat.e_lsb) begin
          cmd.op = dsv_pkg::OP_MUL_GO; cmd.src = dsv_pkg::SRC_ACC;
          ret_next = S_XACC; state_next = S_MUL;
        end else begin
          state_next = S_XSQGO;
        end
      end
      S_XACC: begin cmd.op = dsv_pkg::OP_PUT_ACC; state_next = S_XSQGO; end
      S_XSQGO: begin
        cmd.op = dsv_pkg::OP_MUL_GO; cmd.src = dsv_pkg::SRC_SQ;
        ret_next = S_XBASE; state_next = S_MUL;
      end
      S_XBASE: begin cmd.op = dsv_pkg::OP_PUT_SQ; state_next = S_EXP; end
      S_RY: begin
        cmd.op = dsv_pkg::OP_DIV_GO; cmd.src = dsv_pkg::SRC_Y_P;
        ret_next = S_YPUT; state_next = S_DIV;
      end
      S_YPUT: begin cmd.op = dsv_pkg::OP_BASE_Y; state_next = S_EXP; end
      // v = (g^u1 * y^u2 mod p) mod q
      S_VGO: begin
        cmd.op = dsv_pkg::OP_MUL_GO; cmd.src = dsv_pkg::SRC_V;
        ret_next = S_VRED; state_next = S_MUL;
      end
      S_VRED: begin
        cmd.op = dsv_pkg::OP_DIV_GO; cmd.src = dsv_pkg::SRC_V_Q;
        ret_next = S_OUT; state_next = S_DIV;
      end
      S_OUT: begin cmd.op = dsv_pkg::OP_PUT_OUT; state_next = S_DONE; end
      S_ZERO: begin cmd.op = dsv_pkg::OP_PUT_ZERO; state_next = S_DONE; end
      S_DONE: begin strobe = 1'b1; state_next = S_IDLE; end
      default: state_next = S_IDLE;
    endcase
  end

  assign busy = (state != S_IDLE);

  `DSV_ASSERT_NEXT(a_strobe_idle, clk, rst, strobe, !busy)
  `DSV_ASSERT_IMPL(a_start_load, clk, rst, start && !busy, cmd.op == dsv_pkg::OP_LOAD)
  `DSV_ASSERT_IMPL(a_onehot, clk, rst, 1'b1, $onehot(state))
endmodule
`default_nettype wire

// ===== design/dsa_signature_verify_core.sv =====
// When p or q is zero, the controller passes from acceptance through S_REDS and
// S_ZERO to S_DONE, which raises the strobe; otherwise six divisions, the Euclid
// inverse and two square-and-multiply passes for 32-bit moduli come before it.
// One item at a time; busy is high up to the strobe cycle and the next item
// can be accepted in the cycle after it. Reset restores p=23, q=11, g=4, y=4.
// ----------------------------------------------------------------------------
// dsa_signature_verify_core
// Signature check top level: configuration registers, controller, datapath.
// ----------------------------------------------------------------------------
`default_nettype none
module dsa_signature_verify_core (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  input  wire dsv_pkg::in_item_t   in_item,
  output logic                     busy,
  output logic                     strobe,
  output dsv_pkg::out_item_t       result,
  input  wire logic                cfg_we,
  input  wire logic [1:0]          cfg_index,
  input  wire logic [31:0]         cfg_data
);
  logic [31:0] p, q, g, y;
  dsv_pkg::cmd_t  cmd;
  dsv_pkg::stat_t stat;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      p <= 32'd23; q <= 32'd11; g <= 32'd4; y <= 32'd4;
    end else if (cfg_we) begin
      unique case (cfg_index)
        dsv_pkg::REG_P: p <= cfg_data;
        dsv_pkg::REG_Q: q <= cfg_data;
        dsv_pkg::REG_G: g <= cfg_data;
        dsv_pkg::REG_Y: y <= cfg_data;
        default: ;
      endcase
    end
  end

  dsv_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .stat(stat),
    .cmd(cmd), .busy(busy), .strobe(strobe)
  );

  dsv_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .in_item(in_item),
    .p(p), .q(q), .g(g), .y(y), .stat(stat), .res(result)
  );
endmodule
`default_nettype wire
